// ===== sv/nmea_rmc_position_parser_assert.svh =====
// Assertion macros for the position parser checker.
// Depends on nothing; the checker file includes it.
`ifndef NMEA_RMC_POSITION_PARSER_ASSERT_SVH
`define NMEA_RMC_POSITION_PARSER_ASSERT_SVH

// A property checked at every clock edge outside reset.
`define NRMC_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define NRMC_ASSERT_NEXT(lbl, ck, rn, trig, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (trig) |=> (cons)) else $error(msg);

`endif

// ===== sv/nrmc_pkg.sv =====
// Shared constants, types and small tables of the RMC position parser.
// Used by every module of the block; depends on nothing.
package nrmc_pkg;

	localparam int FRAC_DIGITS = 6;

	localparam longint unsigned POW_MAX = 64'd10 ** FRAC_DIGITS;

	localparam int WHOLE_W   = 17;
	localparam int WHOLE_MAX = 131071;
	localparam int FRAC_W    = $clog2(POW_MAX);
	localparam int POW_W     = $clog2(POW_MAX + 64'd1);
	localparam int FCNT_W    = 3;
	localparam int FIELD_W   = 4;

	localparam int LAT_W     = 28;
	localparam int LON_W     = 29;
	localparam int LAT_LIMIT = 90000000;
	localparam int LON_LIMIT = 180000000;
	localparam int TDATA_W   = ((LAT_W + LON_W + 7) / 8) * 8;

	// Degrees by reciprocal multiply: floor(w * 167773 / 2^24) equals w / 100 over the range.
	localparam int DIV100_MUL = 167773;
	localparam int DIV100_SH  = 24;
	localparam int DIV100_PW  = WHOLE_W + 18;

	localparam int DEG_MAX = WHOLE_MAX / 100;
	localparam int DEG_W   = $clog2(DEG_MAX + 1);
	localparam int MM_W    = 7;
	localparam int DEGU_W  = $clog2(longint'(DEG_MAX) * 64'd1000000 + 64'd1);
	localparam int SUM_W   = DEGU_W + 1;

	// Minutes scaled: n = mm * 10^c + frac, numerator n * 10^6 + 30 * 10^c, divisor 60 * 10^c.
	localparam int N_W   = $clog2(64'd100 * POW_MAX);
	localparam int NUM_W = $clog2(64'd100000000 * POW_MAX);
	localparam int DEN_W = $clog2(64'd60 * POW_MAX + 64'd1);
	localparam int Q_W   = $clog2(100000000 / 60 + 1);
	localparam int CNT_W = $clog2(Q_W);

	localparam logic [FIELD_W-1:0] FLD_LAT      = 4'd2;
	localparam logic [FIELD_W-1:0] FLD_LAT_HEMI = 4'd3;
	localparam logic [FIELD_W-1:0] FLD_LON      = 4'd4;
	localparam logic [FIELD_W-1:0] FLD_LON_HEMI = 4'd5;
	localparam logic [FIELD_W-1:0] FIELD_MAX    = 4'd15;

	localparam logic [2:0] HDR_LAST = 3'd6;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_W      = 8'h57;

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_CONV,
		TS_EMIT
	} top_state_t;

	typedef enum logic [2:0] {
		CV_IDLE,
		CV_SPLIT,
		CV_MIN,
		CV_FRAC,
		CV_SCALE,
		CV_DIV,
		CV_DONE
	} conv_state_t;

	typedef struct packed {
		logic conv_req;
		logic conv_lon;
		logic emit_req;
	} scan_ev_t;

	typedef struct packed {
		logic [WHOLE_W-1:0] whole;
		logic [FRAC_W-1:0]  frac;
		logic [FCNT_W-1:0]  fcnt;
	} field_snap_t;

	typedef struct packed {
		logic [LAT_W-1:0] lat;
		logic [LON_W-1:0] lon;
		logic             south;
		logic             west;
		logic [1:0]       seen;
	} pos_hold_t;

	typedef struct packed {
		logic             done;
		logic             lon;
		logic [LON_W-1:0] micro;
	} conv_res_t;

	function automatic logic [7:0] hdr_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = CH_DOLLAR;
			3'd1: c = 8'h47;
			3'd2: c = 8'h50;
			3'd3: c = 8'h52;
			3'd4: c = 8'h4D;
			3'd5: c = 8'h43;
			3'd6: c = CH_COMMA;
			default: c = CH_DOLLAR;
		endcase
		return c;
	endfunction

	function automatic logic [POW_W-1:0] pow_ten(input logic [FCNT_W-1:0] idx);
		logic [POW_W-1:0] p;
		case (idx)
			3'd0: p = POW_W'(1);
			3'd1: p = POW_W'(10);
			3'd2: p = POW_W'(100);
			3'd3: p = POW_W'(1000);
			3'd4: p = POW_W'(10000);
			3'd5: p = POW_W'(100000);
			3'd6: p = POW_W'(1000000);
			default: p = POW_W'(10000000);
		endcase
		return p;
	endfunction

endpackage

// ===== sv/nmea_rmc_position_parser.sv =====
// Most bytes are taken back to back. A comma or newline that closes the latitude or longitude
// field stalls the input while it is converted: four multiply steps, 21 steps of the shared
// divider, a hand-over of the quotient and a saturating add.
// A newline that ends a sentence waits in an emit state until the output register is free
// and loads its result into that register; the next byte is taken while that result waits.
// Reset clears the header hunt, the sentence state and the output valid at once.
// Top level of the RMC position parser; depends on nrmc_pkg, nrmc_scan, nrmc_conv.
module nmea_rmc_position_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // [7:0] rx_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [nrmc_pkg::TDATA_W-1:0] m_tdata,  // [27:0] latitude_micro, [56:28] longitude_micro
	output logic                         m_tuser   // [0] coords_valid
);
	import nrmc_pkg::*;

	top_state_t st_q;
	top_state_t st_d;

	scan_ev_t    ev;
	field_snap_t snap;
	pos_hold_t   hold;
	conv_res_t   res;

	logic accept;
	logic conv_start;
	logic out_free;
	logic out_load;
	logic emit_pend_q;

	logic               coords_ok;
	logic [LAT_W-1:0]   lat_o;
	logic [LON_W-1:0]   lon_o;
	logic               m_tvalid_q;
	logic [TDATA_W-1:0] m_tdata_q;
	logic               m_tuser_q;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	nrmc_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (s_tdata),
		.res     (res),
		.ev      (ev),
		.snap    (snap),
		.hold    (hold)
	);

	nrmc_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.lon    (ev.conv_lon),
		.snap   (snap),
		.res    (res)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			TS_IDLE: begin
				if (accept && ev.conv_req) begin
					st_d = TS_CONV;
				end else if (accept && ev.emit_req) begin
					st_d = TS_EMIT;
				end
			end
			TS_CONV: if (res.done) st_d = emit_pend_q ? TS_EMIT : TS_IDLE;
			TS_EMIT: if (out_free) st_d = TS_IDLE;
			default: st_d = TS_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		conv_start = 1'b0;
		out_load   = 1'b0;
		case (st_q)
			TS_IDLE: begin
				s_tready   = 1'b1;
				conv_start = s_tvalid && ev.conv_req;
			end
			TS_EMIT: out_load = out_free;
			default: begin
				s_tready   = 1'b0;
				conv_start = 1'b0;
				out_load   = 1'b0;
			end
		endcase
	end

	// An empty position field yields zero coordinates.
	assign coords_ok = (hold.seen == 2'b11);
	assign lat_o = !coords_ok ? '0 : (hold.south ? LAT_W'(0) - hold.lat : hold.lat);
	assign lon_o = !coords_ok ? '0 : (hold.west ? LON_W'(0) - hold.lon : hold.lon);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= TS_IDLE;
			emit_pend_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (accept) begin
				emit_pend_q <= ev.emit_req;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= TDATA_W'({lon_o, lat_o});
			m_tuser_q <= coords_ok;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== sv/nrmc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on nrmc_pkg for the operand and quotient widths.
module nrmc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [nrmc_pkg::NUM_W-1:0] num,
	input  logic [nrmc_pkg::DEN_W-1:0] den,
	output logic                       done,
	output logic [nrmc_pkg::Q_W-1:0]   quot
);
	import nrmc_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [Q_W-1:0]   sh_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;

	// The quotient is known to fit Q_W bits, so the upper numerator bits start below the divisor.
	assign trial = {rem_q, sh_q[Q_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num >> Q_W);
			sh_q  <= num[Q_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			sh_q  <= {sh_q[Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = sh_q;

endmodule

// ===== sv/nrmc_conv.sv =====
// Field-to-microdegree converter: a short sequencer of constant multiplies
// around the shared divider. Depends on nrmc_pkg and nrmc_div.
module nrmc_conv (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      lon,
	input  nrmc_pkg::field_snap_t     snap,
	output nrmc_pkg::conv_res_t       res
);
	import nrmc_pkg::*;

	conv_state_t st_q;
	conv_state_t st_d;

	logic               lon_q;
	logic [WHOLE_W-1:0] whole_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [FCNT_W-1:0]  fcnt_q;
	logic [DEG_W-1:0]   deg_q;
	logic [POW_W-1:0]   pow_q;
	logic [MM_W-1:0]    mm_q;
	logic [DEGU_W-1:0]  degu_q;
	logic [N_W-1:0]     n_q;

	logic [DIV100_PW-1:0] deg_prod;
	logic [WHOLE_W-1:0]   hund;
	logic [NUM_W-1:0]     num;
	logic [DEN_W-1:0]     den;
	logic                 div_start;
	logic                 div_done;
	logic [Q_W-1:0]       quot;
	logic [SUM_W-1:0]     sum;
	logic [SUM_W-1:0]     limit;
	logic [SUM_W-1:0]     micro;

	assign deg_prod = DIV100_PW'(whole_q) * DIV100_PW'(DIV100_MUL);
	assign hund     = WHOLE_W'(deg_q) * WHOLE_W'(100);
	assign num      = NUM_W'(n_q) * NUM_W'(1000000) + NUM_W'(pow_q) * NUM_W'(30);
	assign den      = DEN_W'(pow_q) * DEN_W'(60);

	assign sum   = SUM_W'(degu_q) + SUM_W'(quot);
	assign limit = lon_q ? SUM_W'(LON_LIMIT) : SUM_W'(LAT_LIMIT);
	assign micro = (sum > limit) ? limit : sum;

	nrmc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.quot   (quot)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			CV_IDLE:  if (start) st_d = CV_SPLIT;
			CV_SPLIT: st_d = CV_MIN;
			CV_MIN:   st_d = CV_FRAC;
			CV_FRAC:  st_d = CV_SCALE;
			CV_SCALE: st_d = CV_DIV;
			CV_DIV:   if (div_done) st_d = CV_DONE;
			CV_DONE:  st_d = CV_IDLE;
			default:  st_d = CV_IDLE;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		res.done  = 1'b0;
		case (st_q)
			CV_SCALE: div_start = 1'b1;
			CV_DONE:  res.done  = 1'b1;
			default: begin
				div_start = 1'b0;
				res.done  = 1'b0;
			end
		endcase
	end

	assign res.lon   = lon_q;
	assign res.micro = LON_W'(micro);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= CV_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			CV_IDLE: begin
				if (start) begin
					lon_q   <= lon;
					whole_q <= snap.whole;
					frac_q  <= snap.frac;
					fcnt_q  <= snap.fcnt;
				end
			end
			CV_SPLIT: begin
				deg_q <= DEG_W'(deg_prod >> DIV100_SH);
				pow_q <= pow_ten(fcnt_q);
			end
			CV_MIN: begin
				mm_q   <= MM_W'(whole_q - hund);
				degu_q <= DEGU_W'(DEGU_W'(deg_q) * DEGU_W'(1000000));
			end
			CV_FRAC: begin
				n_q <= N_W'(N_W'(mm_q) * N_W'(pow_q) + N_W'(frac_q));
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/nrmc_scan.sv =====
// Byte scanner: header hunt, field splitting, digit accumulation and the
// held coordinates of the current sentence. Depends on nrmc_pkg.
module nrmc_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            rx_byte,
	input  nrmc_pkg::conv_res_t   res,
	output nrmc_pkg::scan_ev_t    ev,
	output nrmc_pkg::field_snap_t snap,
	output nrmc_pkg::pos_hold_t   hold
);
	import nrmc_pkg::*;

	localparam int W10_W = WHOLE_W + 4;
	localparam int F10_W = FRAC_W + 4;

	logic [2:0]         hdr_cnt_q, hdr_cnt_d;
	logic               in_sent_q, in_sent_d;
	logic [FIELD_W-1:0] field_q, field_d;
	logic [WHOLE_W-1:0] whole_q, whole_d;
	logic [FRAC_W-1:0]  frac_q, frac_d;
	logic [FCNT_W-1:0]  fcnt_q, fcnt_d;
	logic               after_pt_q, after_pt_d;
	logic [LAT_W-1:0]   held_lat_q, held_lat_d;
	logic [LON_W-1:0]   held_lon_q, held_lon_d;
	logic               south_q, south_d;
	logic               west_q, west_d;
	logic [1:0]         seen_q, seen_d;

	logic             is_digit;
	logic             pos_field;
	logic [W10_W-1:0] whole_x10;
	logic [F10_W-1:0] frac_x10;

	assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign pos_field = (field_q == FLD_LAT) || (field_q == FLD_LON);
	assign whole_x10 = W10_W'(whole_q) * W10_W'(10) + W10_W'(rx_byte[3:0]);
	assign frac_x10  = F10_W'(frac_q) * F10_W'(10) + F10_W'(rx_byte[3:0]);

	assign ev.conv_req = in_sent_q && pos_field && ((rx_byte == CH_COMMA) || (rx_byte == CH_NL));
	assign ev.conv_lon = (field_q == FLD_LON);
	assign ev.emit_req = in_sent_q && (rx_byte == CH_NL);

	assign snap.whole = whole_q;
	assign snap.frac  = frac_q;
	assign snap.fcnt  = fcnt_q;

	assign hold.lat   = held_lat_q;
	assign hold.lon   = held_lon_q;
	assign hold.south = south_q;
	assign hold.west  = west_q;
	assign hold.seen  = seen_q;

	always_comb begin
		hdr_cnt_d  = hdr_cnt_q;
		in_sent_d  = in_sent_q;
		field_d    = field_q;
		whole_d    = whole_q;
		frac_d     = frac_q;
		fcnt_d     = fcnt_q;
		after_pt_d = after_pt_q;
		held_lat_d = held_lat_q;
		held_lon_d = held_lon_q;
		south_d    = south_q;
		west_d     = west_q;
		seen_d     = seen_q;
		if (!in_sent_q) begin
			if (rx_byte == hdr_char(hdr_cnt_q)) begin
				if (hdr_cnt_q == HDR_LAST) begin
					hdr_cnt_d  = '0;
					in_sent_d  = 1'b1;
					field_d    = '0;
					whole_d    = '0;
					frac_d     = '0;
					fcnt_d     = '0;
					after_pt_d = 1'b0;
					held_lat_d = '0;
					held_lon_d = '0;
					south_d    = 1'b0;
					west_d     = 1'b0;
					seen_d     = '0;
				end else begin
					hdr_cnt_d = hdr_cnt_q + 3'd1;
				end
			end else begin
				hdr_cnt_d = (rx_byte == CH_DOLLAR) ? 3'd1 : 3'd0;
			end
		end else if (rx_byte == CH_NL) begin
			in_sent_d  = 1'b0;
			hdr_cnt_d  = '0;
			field_d    = '0;
			whole_d    = '0;
			frac_d     = '0;
			fcnt_d     = '0;
			after_pt_d = 1'b0;
		end else if (rx_byte == CH_COMMA) begin
			if (field_q != FIELD_MAX) begin
				field_d = field_q + 4'd1;
			end
			whole_d    = '0;
			frac_d     = '0;
			fcnt_d     = '0;
			after_pt_d = 1'b0;
		end else if (pos_field) begin
			if (is_digit) begin
				if (field_q == FLD_LAT) begin
					seen_d[0] = 1'b1;
				end else begin
					seen_d[1] = 1'b1;
				end
				if (!after_pt_q) begin
					whole_d = (whole_x10 > W10_W'(WHOLE_MAX)) ? WHOLE_W'(WHOLE_MAX)
					                                          : whole_x10[WHOLE_W-1:0];
				end else if (fcnt_q < FCNT_W'(FRAC_DIGITS)) begin
					// Digits past the kept precision are dropped.
					frac_d = frac_x10[FRAC_W-1:0];
					fcnt_d = fcnt_q + 3'd1;
				end
			end else if (rx_byte == CH_POINT) begin
				after_pt_d = 1'b1;
			end
		end else if (field_q == FLD_LAT_HEMI) begin
			if (rx_byte == CH_S) begin
				south_d = 1'b1;
			end
		end else if (field_q == FLD_LON_HEMI) begin
			if (rx_byte == CH_W) begin
				west_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q  <= '0;
			in_sent_q  <= 1'b0;
			field_q    <= '0;
			whole_q    <= '0;
			frac_q     <= '0;
			fcnt_q     <= '0;
			after_pt_q <= 1'b0;
			held_lat_q <= '0;
			held_lon_q <= '0;
			south_q    <= 1'b0;
			west_q     <= 1'b0;
			seen_q     <= '0;
		end else if (accept) begin
			hdr_cnt_q  <= hdr_cnt_d;
			in_sent_q  <= in_sent_d;
			field_q    <= field_d;
			whole_q    <= whole_d;
			frac_q     <= frac_d;
			fcnt_q     <= fcnt_d;
			after_pt_q <= after_pt_d;
			held_lat_q <= held_lat_d;
			held_lon_q <= held_lon_d;
			south_q    <= south_d;
			west_q     <= west_d;
			seen_q     <= seen_d;
		end else if (res.done) begin
			// No item is accepted while a conversion runs, so the two never collide.
			if (res.lon) begin
				held_lon_q <= res.micro;
			end else begin
				held_lat_q <= LAT_W'(res.micro);
			end
		end
	end

endmodule

// ===== sv/nrmc_chk.sv =====
// Port-level checker of the RMC position parser, bound to the top level.
// Depends on nrmc_pkg and the assertion macro header.
`include "nmea_rmc_position_parser_assert.svh"

module nrmc_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [nrmc_pkg::TDATA_W-1:0] m_tdata,
	input logic                         m_tuser
);
	import nrmc_pkg::*;

	localparam logic signed [LAT_W-1:0] LAT_MAX_S = LAT_W'(LAT_LIMIT);
	localparam logic signed [LON_W-1:0] LON_MAX_S = LON_W'(LON_LIMIT);

	logic signed [LAT_W-1:0] lat_v;
	logic signed [LON_W-1:0] lon_v;

	assign lat_v = m_tdata[LAT_W-1:0];
	assign lon_v = m_tdata[LAT_W+LON_W-1:LAT_W];

	`NRMC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")

	`NRMC_ASSERT(a_empty_zero, clk, arst_n, (m_tvalid && !m_tuser) |-> (m_tdata == '0), "item without a position carries coordinates")

	`NRMC_ASSERT(a_lat_range, clk, arst_n, m_tvalid |-> (lat_v <= LAT_MAX_S) && (lat_v >= -LAT_MAX_S), "latitude out of range")

	`NRMC_ASSERT(a_lon_range, clk, arst_n, m_tvalid |-> (lon_v <= LON_MAX_S) && (lon_v >= -LON_MAX_S), "longitude out of range")

	`NRMC_ASSERT(a_emit_busy, clk, arst_n, $rose(m_tvalid) |-> !$past(s_tready), "result appeared without a closing cycle")

endmodule

bind nmea_rmc_position_parser nrmc_chk u_nrmc_chk (.*);

// ===== dv/tb_nmea_rmc_position_parser.sv =====
// Self-checking testbench for the RMC position parser: streams bytes in, checks each fix out.
// Depends on nrmc_pkg and nmea_rmc_position_parser; a built-in predictor supplies the expected fixes.
module tb_nmea_rmc_position_parser;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LW = nrmc_pkg::LAT_W;
	localparam int NW = nrmc_pkg::LON_W;
	localparam int DW = nrmc_pkg::TDATA_W;

	localparam longint unsigned LAT_CAP   = 64'd90000000;
	localparam longint unsigned LON_CAP   = 64'd180000000;
	localparam int unsigned     WHOLE_CAP = 131071;
	localparam int unsigned     FIELD_TOP = 15;

	localparam logic [55:0] HDR_TEXT = "$GPRMC,";

	localparam logic [7:0] ASC_NL     = 8'h0A;
	localparam logic [7:0] ASC_CR     = 8'h0D;
	localparam logic [7:0] ASC_COMMA  = 8'h2C;
	localparam logic [7:0] ASC_DOLLAR = 8'h24;
	localparam logic [7:0] ASC_POINT  = 8'h2E;
	localparam logic [7:0] ASC_ZERO   = 8'h30;
	localparam logic [7:0] ASC_NINE   = 8'h39;
	localparam logic [7:0] ASC_S      = 8'h53;
	localparam logic [7:0] ASC_W      = 8'h57;
	localparam logic [7:0] ASC_N      = 8'h4E;
	localparam logic [7:0] ASC_E      = 8'h45;

	typedef struct packed {
		logic [LW-1:0] lat;
		logic [NW-1:0] lon;
		logic          ok;
	} position_fix_t;

	logic          clk      = 1'b0;
	logic          arst_n   = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [7:0]    s_tdata  = 8'h00;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [DW-1:0] m_tdata;
	logic          m_tuser;

	nmea_rmc_position_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	position_fix_t expected_fixes[$];
	int            mismatch_count  = 0;
	int            bytes_sent      = 0;
	int            fixes_predicted = 0;
	int            send_idle_pct   = 0;
	int            recv_stall_pct  = 0;
	int            hold_req        = 0;
	int            hold_left       = 0;

	// Predictor copy of the parser state.
	int unsigned     hunt_pos   = 0;
	bit              in_msg     = 1'b0;
	int unsigned     field_idx  = 0;
	int unsigned     whole_acc  = 0;
	int unsigned     frac_acc   = 0;
	int unsigned     frac_cnt   = 0;
	bit              seen_point = 1'b0;
	longint unsigned lat_mag    = 0;
	longint unsigned lon_mag    = 0;
	bit              is_south   = 1'b0;
	bit              is_west    = 1'b0;
	bit [1:0]        digit_mask = 2'b00;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	task automatic clear_field();
		whole_acc  = 0;
		frac_acc   = 0;
		frac_cnt   = 0;
		seen_point = 1'b0;
	endtask

	// Degrees plus minutes over 60, rounded half up, in microdegrees.
	function automatic longint unsigned field_micro(input longint unsigned cap);
		longint unsigned scale;
		longint unsigned whole;
		longint unsigned num;
		longint unsigned den;
		longint unsigned micro;
		scale = 1;
		repeat (frac_cnt) scale = scale * 10;
		whole = whole_acc;
		num   = ((whole % 100) * scale + frac_acc) * 1000000;
		den   = 60 * scale;
		micro = (whole / 100) * 1000000 + (num + den / 2) / den;
		return (micro > cap) ? cap : micro;
	endfunction

	task automatic close_field();
		if (field_idx == 2)
			lat_mag = field_micro(LAT_CAP);
		else if (field_idx == 4)
			lon_mag = field_micro(LON_CAP);
	endtask

	task automatic track_byte(input logic [7:0] b);
		position_fix_t   fix;
		int unsigned     w;
		int unsigned     d;
		longint unsigned v;
		d = b - ASC_ZERO;
		if (!in_msg) begin
			if (b == HDR_TEXT[8*(6-hunt_pos) +: 8]) begin
				hunt_pos++;
				if (hunt_pos >= 7) begin
					hunt_pos   = 0;
					in_msg     = 1'b1;
					field_idx  = 0;
					clear_field();
					lat_mag    = 0;
					lon_mag    = 0;
					is_south   = 1'b0;
					is_west    = 1'b0;
					digit_mask = 2'b00;
				end
			end else begin
				hunt_pos = (b == ASC_DOLLAR) ? 1 : 0;
			end
		end else if (b == ASC_NL) begin
			close_field();
			fix.ok  = (digit_mask == 2'b11);
			fix.lat = '0;
			fix.lon = '0;
			if (fix.ok) begin
				v       = is_south ? (64'd0 - lat_mag) : lat_mag;
				fix.lat = v[LW-1:0];
				v       = is_west ? (64'd0 - lon_mag) : lon_mag;
				fix.lon = v[NW-1:0];
			end
			expected_fixes.push_back(fix);
			fixes_predicted++;
			in_msg    = 1'b0;
			hunt_pos  = 0;
			field_idx = 0;
			clear_field();
		end else if (b == ASC_COMMA) begin
			close_field();
			if (field_idx < FIELD_TOP)
				field_idx++;
			clear_field();
		end else if (field_idx == 2 || field_idx == 4) begin
			if (b >= ASC_ZERO && b <= ASC_NINE) begin
				digit_mask |= (field_idx == 2) ? 2'b01 : 2'b10;
				if (!seen_point) begin
					w         = whole_acc * 10 + d;
					whole_acc = (w > WHOLE_CAP) ? WHOLE_CAP : w;
				end else if (frac_cnt < nrmc_pkg::FRAC_DIGITS) begin
					frac_acc = frac_acc * 10 + d;
					frac_cnt++;
				end
			end else if (b == ASC_POINT) begin
				seen_point = 1'b1;
			end
		end else if (field_idx == 3) begin
			if (b == ASC_S)
				is_south = 1'b1;
		end else if (field_idx == 5) begin
			if (b == ASC_W)
				is_west = 1'b1;
		end
	endtask

	// Offers one byte, waits for the handshake, then feeds it to the predictor.
	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
		track_byte(b);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_line(input string s, input bit with_cr);
		send_text(s);
		if (with_cr)
			send_byte(ASC_CR);
		send_byte(ASC_NL);
	endtask

	task automatic send_digits(input int n);
		repeat (n) send_byte(8'(ASC_ZERO + $urandom_range(0, 9)));
	endtask

	task automatic send_number(input int unsigned value, input int ndig);
		int unsigned p;
		p = 1;
		repeat (ndig - 1) p = p * 10;
		repeat (ndig) begin
			send_byte(8'(ASC_ZERO + (value / p) % 10));
			p = p / 10;
		end
	endtask

	task automatic send_coord(input int deg_digits, input int unsigned max_deg);
		int mode;
		mode = $urandom_range(0, 99);
		if (mode < 8) begin
			// empty field
		end else if (mode < 16) begin
			send_digits($urandom_range(5, 12));
			if ($urandom_range(0, 1)) begin
				send_byte(ASC_POINT);
				send_digits($urandom_range(0, 9));
			end
		end else if (mode < 24) begin
			repeat ($urandom_range(1, 8)) begin
				case ($urandom_range(0, 2))
					0: send_byte(8'(ASC_ZERO + $urandom_range(0, 9)));
					1: send_byte(ASC_POINT);
					default: send_byte(8'($urandom_range(0, 255)));
				endcase
			end
		end else if (mode < 30) begin
			send_number(max_deg, deg_digits);
			send_text("59.");
			send_digits($urandom_range(4, 8));
		end else begin
			send_number($urandom_range(0, max_deg), deg_digits);
			send_number($urandom_range(0, 59), 2);
			if ($urandom_range(0, 9) != 0) begin
				send_byte(ASC_POINT);
				send_digits($urandom_range(0, 8));
			end
		end
	endtask

	task automatic send_hemi(input logic [7:0] pos, input logic [7:0] neg);
		int r;
		r = $urandom_range(0, 9);
		if (r == 1) begin
			send_byte(pos);
			send_byte(neg);
		end else if (r >= 2 && r < 6) begin
			send_byte(pos);
		end else if (r >= 6) begin
			send_byte(neg);
		end
	endtask

	// One sentence with random content; a few are preceded by noise or cut short.
	task automatic send_sentence();
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) == 0)
			send_text("$GPRM");
		send_text("$GPRMC,");
		send_digits($urandom_range(0, 3));
		send_byte(ASC_COMMA);
		if ($urandom_range(0, 1))
			send_text("A");
		send_byte(ASC_COMMA);
		send_coord(2, 90);
		send_byte(ASC_COMMA);
		send_hemi(ASC_N, ASC_S);
		send_byte(ASC_COMMA);
		send_coord(3, 180);
		send_byte(ASC_COMMA);
		send_hemi(ASC_E, ASC_W);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 12)) begin
				send_byte(ASC_COMMA);
				send_digits($urandom_range(0, 2));
			end
		end
		if ($urandom_range(0, 19) != 0) begin
			if ($urandom_range(0, 9) < 7)
				send_byte(ASC_CR);
			send_byte(ASC_NL);
		end
	endtask

	task automatic run_sentences(input int byte_goal, input int fix_goal);
		int byte_base;
		int fix_base;
		byte_base = bytes_sent;
		fix_base  = fixes_predicted;
		while (bytes_sent - byte_base < byte_goal || fixes_predicted - fix_base < fix_goal)
			send_sentence();
	endtask

	task automatic test_directed_cases();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_line("$GPRMC,,,0000.000000,N,00000.000000,E", 1'b1);
		send_line("$GPRMC,,,8959.999999,N,17959.999999,E", 1'b0);
		send_line("$GPRMC,,,9000.0,S,18000.0,W", 1'b1);
		send_line("$GPRMC,,,9959.99,S,99959.99,W", 1'b0);
		send_line("$GPRMC,,,99999999,N,9999999999,E", 1'b0);
		send_line("$GPRMC,,,1234.56789012,N,01234.5,E", 1'b0);
		send_line("$GPRMC,,,12a3.4.5,NS,x1.2,EW", 1'b0);
		// Both fractions land exactly on half a microdegree or just below it.
		send_line("$GPRMC,,,0000.00003,N,00000.000029,E", 1'b0);
		send_line("$GP$GPRMC,,,1,S,2,W", 1'b0);
		send_line("", 1'b0);
		send_line("$GPRMX,1,2,3,4,5", 1'b1);
		send_line("$GPRMC,,,,N,12.0,E", 1'b0);
		send_line("$GPRMC,,,1200.0,N", 1'b0);
		send_line("$GPRMC,a,b,c,d,e,f,g,h,i,j,k,l,m,n,o,p,q,r,5,6", 1'b0);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("$GPRMC,,,");
		send_byte(8'hFF);
		send_byte(8'h00);
		send_line("45,S,7,W", 1'b0);
	endtask

	task automatic test_stream_no_idle();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_sentences(70, 2);
	endtask

	task automatic test_stream_sender_idle();
		send_idle_pct  = 74;
		recv_stall_pct = 0;
		run_sentences(70, 2);
	endtask

	task automatic test_stream_receiver_stall();
		send_idle_pct  = 0;
		recv_stall_pct = 74;
		run_sentences(70, 2);
	endtask

	task automatic test_stream_both_idle();
		send_idle_pct  = 12;
		recv_stall_pct = 12;
		run_sentences(70, 2);
	endtask

	// The receiver holds off long enough for a second fix to back up into the input.
	task automatic test_output_hold_pressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 400;
		repeat (4) send_sentence();
		send_line("$GPRMC,,,4916.45,N,12311.12,W", 1'b1);
	endtask

	task automatic finish_run();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (expected_fixes.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (64) @(posedge clk);
		if (expected_fixes.size() != 0)
			report_mismatch("fixes never delivered", 0, expected_fixes.size());
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	endtask

	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		position_fix_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_fixes.size() == 0) begin
				report_mismatch("fix with none pending", m_tdata, 0);
			end else begin
				want = expected_fixes.pop_front();
				if (m_tdata[LW-1:0] != want.lat)
					report_mismatch("latitude_micro", m_tdata[LW-1:0], want.lat);
				if (m_tdata[LW+NW-1:LW] != want.lon)
					report_mismatch("longitude_micro", m_tdata[LW+NW-1:LW], want.lon);
				if (m_tuser != want.ok)
					report_mismatch("coords_valid", m_tuser, want.ok);
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_stream_no_idle();
		test_stream_sender_idle();
		test_stream_receiver_stall();
		test_stream_both_idle();
		test_output_hold_pressure();
		finish_run();
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/nrmc_pkg.sv
sv/nrmc_div.sv
sv/nrmc_conv.sv
sv/nrmc_scan.sv
sv/nmea_rmc_position_parser.sv
sv/nrmc_chk.sv
dv/tb_nmea_rmc_position_parser.sv
